/* hw/rtl/vmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_pkg: shared types and constants
// Widths of the coordinate datapath and the records passed between cells.
// ----------------------------------------------------------------------------
package vmt_pkg;
    localparam int CW      = 32;            // coordinate width
    localparam int SW      = CW - 1;        // step width
    localparam int MW      = CW + 1;        // magnitude of a difference
    localparam int SQW     = 2 * MW + 1;    // sum of squares
    localparam int RW      = MW;            // root width
    localparam int NUMW    = MW + SW;       // dividend width
    localparam int QW      = NUMW;          // quotient width

    // Record passed down the root chain
    typedef struct packed {
        logic [CW-1:0]  cur_x;
        logic [CW-1:0]  cur_y;
        logic [CW-1:0]  target_x;
        logic [CW-1:0]  target_y;
        logic [SW-1:0]  step;
        logic [MW-1:0]  mx;
        logic [MW-1:0]  my;
        logic           nx;
        logic           ny;
        logic [SQW-1:0] sq;     // remaining radicand
        logic [RW-1:0]  root;   // root bits found so far
    } root_rec_t;

    // Record passed down the divider chain
    typedef struct packed {
        logic [CW-1:0]   cur_x;
        logic [CW-1:0]   cur_y;
        logic [CW-1:0]   target_x;
        logic [CW-1:0]   target_y;
        logic            nx;
        logic            ny;
        logic            reached;
        logic [RW-1:0]   len;
        logic [NUMW-1:0] num_x;
        logic [NUMW-1:0] num_y;
        logic [RW:0]     rem_x;
        logic [RW:0]     rem_y;
    } div_rec_t;
endpackage

/* hw/rtl/vmt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_if: valid/ready channel
// Generic handshake channel carrying one payload type.
// ----------------------------------------------------------------------------
interface vmt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/vmt_root_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_root_cell: one root bit
// Settles one bit of the integer square root, using the restoring method.
// ----------------------------------------------------------------------------
module vmt_root_cell
    import vmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic [6:0] bit_pos,
    input  logic      in_valid,
    input  root_rec_t in_rec,
    output logic      out_valid,
    output root_rec_t out_rec
);
    logic      valid_reg;
    root_rec_t rec_reg;
    root_rec_t rec_next;
    logic [SQW+1:0] trial;
    logic [SQW+1:0] rootw;

    // Try root | bit; subtract (2*root*2^b + 2^2b) from remaining radicand
    always_comb
    begin
        rec_next = in_rec;
        rootw = {{(SQW+2-RW){1'b0}}, in_rec.root};
        trial = (rootw << (bit_pos + 7'd1)) + ((SQW+2)'(1) << (2 * bit_pos));
        if (trial <= {2'b00, in_rec.sq})
        begin
            rec_next.sq   = SQW'({2'b00, in_rec.sq} - trial);
            rec_next.root = in_rec.root | (RW'(1) << bit_pos);
        end
    end

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rec_reg <= rec_next;
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;
endmodule

/* hw/rtl/vmt_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_div_cell: one quotient bit
// Shifts one dividend bit into each remainder and settles one quotient bit
// for both coordinates.
// ----------------------------------------------------------------------------
module vmt_div_cell
    import vmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  div_rec_t in_rec,
    output logic     out_valid,
    output div_rec_t out_rec
);
    logic     valid_reg;
    div_rec_t rec_reg;
    div_rec_t rec_next;
    logic [RW+1:0] rx;
    logic [RW+1:0] ry;
    logic [RW+1:0] dv;

    // Shift in the top dividend bit, subtract the length when it fits
    always_comb
    begin
        rec_next = in_rec;
        dv = {2'b00, in_rec.len};
        rx = {in_rec.rem_x, in_rec.num_x[NUMW-1]};
        ry = {in_rec.rem_y, in_rec.num_y[NUMW-1]};
        rec_next.num_x = {in_rec.num_x[NUMW-2:0], 1'b0};
        rec_next.num_y = {in_rec.num_y[NUMW-2:0], 1'b0};
        if (rx >= dv)
        begin
            rx = rx - dv;
            rec_next.num_x[0] = 1'b1;
        end
        if (ry >= dv)
        begin
            ry = ry - dv;
            rec_next.num_y[0] = 1'b1;
        end
        rec_next.rem_x = rx[RW:0];
        rec_next.rem_y = ry[RW:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rec_reg <= rec_next;
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;
endmodule

/* hw/rtl/vector_move_towards_2d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_move_towards_2d: step a 2D point toward a target
// Pipelined length, compare and scale of a Q16.16 move-towards.
// ----------------------------------------------------------------------------
// Usage:
//   in  : sink channel with cur_x, cur_y, target_x, target_y, max_step.
//   out : source channel with new_x, new_y, reached.
// One request is taken every cycle unless the receiver stalls. The pipeline is a chain of cells:
// one input stage (differences), one squaring stage, one stage summing the
// squares, RW = 33 root cells (one root bit each), one stage forming
// d*step, NUMW = 64 divider cells (one quotient bit each), and one output
// stage adding the move, or taking the target once it is reached.
// The whole chain advances together; when the receiver stalls, every cell
// holds and ready drops while the output register is full and not taken,
// so no new request enters until the result leaves, even if bubbles remain.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module vector_move_towards_2d
    import vmt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    vmt_if.sink   in_ch,
    vmt_if.source out_ch
);
    logic adv;

    // Stage A: differences and magnitudes
    logic            a_valid_reg;
    logic [CW-1:0]   a_cx_reg, a_cy_reg, a_tx_reg, a_ty_reg;
    logic [SW-1:0]   a_step_reg;
    logic [MW-1:0]   a_mx_reg, a_my_reg;
    logic            a_nx_reg, a_ny_reg;
    logic [MW-1:0]   dx, dy;

    // Stage B: squares
    logic            b_valid_reg;
    root_rec_t       b_rec_reg;
    logic [2*MW-1:0] b_sqx_reg, b_sqy_reg;

    // Stage C: sum feeds root chain
    logic            c_valid_reg;
    root_rec_t       c_rec_reg;

    logic            rv [RW+1];
    root_rec_t       rr [RW+1];

    // Stage D: products
    logic            d_valid_reg;
    div_rec_t        d_rec_reg;

    logic            dvv [NUMW+1];
    div_rec_t        dvr [NUMW+1];

    // Output register
    logic            o_valid_reg;
    logic [CW-1:0]   o_x_reg, o_y_reg;
    logic            o_reached_reg;

    assign adv = !o_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    assign dx = MW'(signed'(in_ch.data.target_x)) - MW'(signed'(in_ch.data.cur_x));
    assign dy = MW'(signed'(in_ch.data.target_y)) - MW'(signed'(in_ch.data.cur_y));

    // Valid bits of the stages outside the cell chains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_ch.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= rv[RW];
            o_valid_reg <= dvv[NUMW];
        end
    end

    // Front payload: differences, squares, sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cx_reg   <= in_ch.data.cur_x;
            a_cy_reg   <= in_ch.data.cur_y;
            a_tx_reg   <= in_ch.data.target_x;
            a_ty_reg   <= in_ch.data.target_y;
            a_step_reg <= in_ch.data.max_step;
            a_nx_reg   <= dx[MW-1];
            a_ny_reg   <= dy[MW-1];
            a_mx_reg   <= dx[MW-1] ? MW'(-dx) : dx;
            a_my_reg   <= dy[MW-1] ? MW'(-dy) : dy;

            b_rec_reg.cur_x    <= a_cx_reg;
            b_rec_reg.cur_y    <= a_cy_reg;
            b_rec_reg.target_x <= a_tx_reg;
            b_rec_reg.target_y <= a_ty_reg;
            b_rec_reg.step     <= a_step_reg;
            b_rec_reg.mx       <= a_mx_reg;
            b_rec_reg.my       <= a_my_reg;
            b_rec_reg.nx       <= a_nx_reg;
            b_rec_reg.ny       <= a_ny_reg;
            b_rec_reg.sq       <= '0;
            b_rec_reg.root     <= '0;
            b_sqx_reg <= a_mx_reg * a_mx_reg;
            b_sqy_reg <= a_my_reg * a_my_reg;

            c_rec_reg.cur_x    <= b_rec_reg.cur_x;
            c_rec_reg.cur_y    <= b_rec_reg.cur_y;
            c_rec_reg.target_x <= b_rec_reg.target_x;
            c_rec_reg.target_y <= b_rec_reg.target_y;
            c_rec_reg.step     <= b_rec_reg.step;
            c_rec_reg.mx       <= b_rec_reg.mx;
            c_rec_reg.my       <= b_rec_reg.my;
            c_rec_reg.nx       <= b_rec_reg.nx;
            c_rec_reg.ny       <= b_rec_reg.ny;
            c_rec_reg.root     <= b_rec_reg.root;
            c_rec_reg.sq       <= {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
        end
    end

    assign rv[0] = c_valid_reg;
    assign rr[0] = c_rec_reg;

    // Root chain, most significant bit first
    for (genvar i = 0; i < RW; i++)
    begin : g_root
        vmt_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .bit_pos   (7'(RW - 1 - i)),
            .in_valid  (rv[i]),
            .in_rec    (rr[i]),
            .out_valid (rv[i+1]),
            .out_rec   (rr[i+1])
        );
    end

    // Stage D: compare length with step and form the dividends
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_rec_reg.cur_x    <= rr[RW].cur_x;
            d_rec_reg.cur_y    <= rr[RW].cur_y;
            d_rec_reg.target_x <= rr[RW].target_x;
            d_rec_reg.target_y <= rr[RW].target_y;
            d_rec_reg.nx       <= rr[RW].nx;
            d_rec_reg.ny       <= rr[RW].ny;
            d_rec_reg.reached  <= (rr[RW].root <= {2'b00, rr[RW].step});
            d_rec_reg.len      <= rr[RW].root;
            d_rec_reg.num_x    <= rr[RW].mx * rr[RW].step;
            d_rec_reg.num_y    <= rr[RW].my * rr[RW].step;
            d_rec_reg.rem_x    <= '0;
            d_rec_reg.rem_y    <= '0;
        end
    end

    assign dvv[0] = d_valid_reg;
    assign dvr[0] = d_rec_reg;

    // Divider chain
    for (genvar j = 0; j < NUMW; j++)
    begin : g_div
        vmt_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dvv[j]),
            .in_rec    (dvr[j]),
            .out_valid (dvv[j+1]),
            .out_rec   (dvr[j+1])
        );
    end

    // Apply the move; the move never passes the target so no clamp is needed
    logic [CW-1:0] res_x, res_y;
    always_comb
    begin
        res_x = dvr[NUMW].nx ? dvr[NUMW].cur_x - dvr[NUMW].num_x[CW-1:0]
                             : dvr[NUMW].cur_x + dvr[NUMW].num_x[CW-1:0];
        res_y = dvr[NUMW].ny ? dvr[NUMW].cur_y - dvr[NUMW].num_y[CW-1:0]
                             : dvr[NUMW].cur_y + dvr[NUMW].num_y[CW-1:0];
        if (dvr[NUMW].reached)
        begin
            res_x = dvr[NUMW].target_x;
            res_y = dvr[NUMW].target_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_x_reg       <= res_x;
            o_y_reg       <= res_y;
            o_reached_reg <= dvr[NUMW].reached;
        end
    end

    assign out_ch.valid        = o_valid_reg;
    assign out_ch.data.new_x   = o_x_reg;
    assign out_ch.data.new_y   = o_y_reg;
    assign out_ch.data.reached = o_reached_reg;
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vector_move_towards_2d
// Streams move requests through the pipeline under several idle and stall
// patterns. Every accepted request is scored by a bit-exact model of the
// wide length, compare, scale and clamp. Each result is compared with the
// oldest pending move.
// ----------------------------------------------------------------------------
module tb;
    import vmt_pkg::*;

    typedef struct packed {
        logic [CW-1:0] cur_x;
        logic [CW-1:0] cur_y;
        logic [CW-1:0] target_x;
        logic [CW-1:0] target_y;
        logic [SW-1:0] max_step;
    } move_req_t;

    typedef struct packed {
        logic [CW-1:0] new_x;
        logic [CW-1:0] new_y;
        logic          reached;
    } move_res_t;

    localparam int PIPE_LAT    = 102;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cnt;
    move_res_t pending_moves[$];

    vmt_if #(.T(move_req_t)) in_ch();
    vmt_if #(.T(move_res_t)) out_ch();

    vector_move_towards_2d uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Saturate a wide signed sum to the coordinate range
    function automatic logic [CW-1:0] clamp_coord(logic signed [67:0] v);
        if (v > 68'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -68'sd2147483648)
            return 32'h8000_0000;
        return v[CW-1:0];
    endfunction

    // Compute the expected move for one request
    function automatic move_res_t predict_move(move_req_t r);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [32:0]  mx;
        logic [32:0]  my;
        logic [127:0] sq;
        logic [127:0] trial;
        logic [127:0] len;
        logic [127:0] qx;
        logic [127:0] qy;
        logic signed [67:0] sx;
        logic signed [67:0] sy;
        move_res_t res;
        dx = {{2{r.target_x[31]}}, r.target_x} - {{2{r.cur_x[31]}}, r.cur_x};
        dy = {{2{r.target_y[31]}}, r.target_y} - {{2{r.cur_y[31]}}, r.cur_y};
        mx = dx[33] ? 33'(-dx) : 33'(dx);
        my = dy[33] ? 33'(-dy) : 33'(dy);
        sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        len = '0;
        for (int b = 52; b >= 0; b--)
        begin
            trial = len | (128'd1 << b);
            if (trial * trial <= sq)
                len = trial;
        end
        if (len == 0 || len <= 128'(r.max_step))
        begin
            res.new_x   = r.target_x;
            res.new_y   = r.target_y;
            res.reached = 1'b1;
            return res;
        end
        qx = (128'(mx) * 128'(r.max_step)) / len;
        qy = (128'(my) * 128'(r.max_step)) / len;
        sx = $signed({{36{r.cur_x[31]}}, r.cur_x});
        sy = $signed({{36{r.cur_y[31]}}, r.cur_y});
        sx = dx[33] ? sx - $signed({4'b0, qx[63:0]}) : sx + $signed({4'b0, qx[63:0]});
        sy = dy[33] ? sy - $signed({4'b0, qy[63:0]}) : sy + $signed({4'b0, qy[63:0]});
        res.new_x   = clamp_coord(sx);
        res.new_y   = clamp_coord(sy);
        res.reached = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        errors++;
    endtask

    // Record each accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            pending_moves.push_back(predict_move(in_ch.data));
    end

    // Score each accepted result
    always @(posedge clk)
    begin
        move_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_moves.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                want = pending_moves.pop_front();
                if (out_ch.data.new_x !== want.new_x)
                    report_mismatch("new_x", out_ch.data.new_x, want.new_x);
                if (out_ch.data.new_y !== want.new_y)
                    report_mismatch("new_y", out_ch.data.new_y, want.new_y);
                if (out_ch.data.reached !== want.reached)
                    report_mismatch("reached", CW'(out_ch.data.reached),
                                    CW'(want.reached));
            end
        end
    end

    // Drive receiver ready; a long hold-off overrides random stalls
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one request and hold it until taken
    task automatic send_move(move_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        drop_valid();
        while (pending_moves.size() != 0)
            @(posedge clk);
    endtask

    function automatic move_req_t mk(int cx, int cy, int tx, int ty, logic [SW-1:0] st);
        move_req_t r;
        r.cur_x = cx;
        r.cur_y = cy;
        r.target_x = tx;
        r.target_y = ty;
        r.max_step = st;
        return r;
    endfunction

    // Pick a coordinate: full width, a small signed value, or one near either end
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed(20'($urandom)));
            2: return 32'($signed(12'($urandom)));
            default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                              : 32'h8000_0000 + $urandom_range(3);
        endcase
    endfunction

    task automatic test_directed();
        send_move(mk(0, 0, 0, 0, 0));
        send_move(mk(5, -7, 5, -7, 31'h7fff_ffff));
        send_move(mk(0, 0, 300, 400, 0));
        send_move(mk(0, 0, 300, 400, 500));
        send_move(mk(0, 0, 300, 400, 499));
        send_move(mk(0, 0, 300, 400, 250));
        send_move(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1));
        send_move(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     31'h7fff_ffff));
        send_move(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     31'h4000_0000));
        send_move(mk(32'h7fff_ffff, 0, 32'h8000_0000, 0, 31'h7fff_ffff));
        send_move(mk(32'h7fff_ffff, 0, 32'h8000_0000, 0, 31'h7fff_fffe));
        send_move(mk(0, 32'h8000_0000, 0, 32'h7fff_ffff, 31'h1234_5678));
        send_move(mk(-65536, 65536, 65536, -65536, 65536));
        send_move(mk(1, 1, 2, 2, 1));
        send_move(mk(1, 1, 0, 0, 0));
        send_move(mk(100, 0, -100, 0, 31'h7fff_ffff));
        send_move(mk(-3, 9, 4, -20, 7));
        wait_drain();
    endtask

    task automatic test_random(int n);
        move_req_t r;
        for (int i = 0; i < n; i++)
        begin
            r.cur_x    = rand_coord();
            r.cur_y    = rand_coord();
            r.target_x = $urandom_range(4) == 0 ? r.cur_x : rand_coord();
            r.target_y = $urandom_range(4) == 0 ? r.cur_y : rand_coord();
            case ($urandom_range(3))
                0: r.max_step = SW'($urandom);
                1: r.max_step = SW'($urandom_range(65535));
                2: r.max_step = SW'(32'h7fff_ffff - $urandom_range(7));
                default: r.max_step = SW'($urandom_range(1 << 22));
            endcase
            send_move(r);
        end
        wait_drain();
    endtask

    // Stall the receiver for a long stretch while requests keep coming
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cnt <= 400;
        test_random(300);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400);
        send_idle_pct = 67;
        test_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_random(400);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        test_random(400);
        test_backpressure();

        wait_drain();
        repeat (PIPE_LAT + 20) @(posedge clk);
        if (errors == 0 && pending_moves.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
